/* sv/svdbs_pkg.sv */
package svdbs_pkg;
  localparam int MaxDim = 16;
  localparam int IdxW = 4;
  localparam int DataW = 32;

  localparam logic [2:0] OP_WR_U = 3'd0;
  localparam logic [2:0] OP_WR_V = 3'd1;
  localparam logic [2:0] OP_WR_W = 3'd2;
  localparam logic [2:0] OP_WR_B = 3'd3;
  localparam logic [2:0] OP_SOLVE = 3'd4;

  localparam logic [1:0] REG_SIZE = 2'd0;
  localparam logic [1:0] REG_CUTOFF = 2'd1;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage

/* sv/svdbs_ram.sv */
module svdbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/svdbs_div.sv */
// Signed 64/32 restoring divider, one quotient bit a cycle, toward zero,
// saturated to 32 bits.
module svdbs_div import svdbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic [6:0]  cnt;
  logic        neg;
  logic [63:0] rem_q;
  logic [64:0] rem;
  logic [32:0] dv;
  logic [64:0] shifted;
  logic [63:0] mag;
  logic [31:0] sat;

  assign shifted = {rem[63:0], rem_q[63]};

  // final magnitude is in rem_q (quotient bits)
  assign mag = rem_q;
  always_comb begin
    if (neg) sat = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(~mag + 64'd1);
    else sat = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
        neg <= req.num[63] ^ req.den[31];
        rem_q <= req.num[63] ? (~req.num + 64'd1) : req.num;
        dv <= req.den[31] ? (33'd0 - {1'b1, req.den}) : {1'b0, req.den};
        rem <= '0;
      end else if (busy) begin
        // shift one dividend bit in, subtract if it fits
        if (shifted >= {32'd0, dv}) begin
          rem <= shifted - {32'd0, dv};
          rem_q <= {rem_q[62:0], 1'b1};
        end else begin
          rem <= shifted;
          rem_q <= {rem_q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = sat;
endmodule

/* sv/svd_back_substitution.sv */
// SVD back substitution with rank truncation, Q16.16.
// Input channel s_axis_*: tdata = {value[31:0], col[3:0], row[3:0]} from the
// high bit down, tuser = operation. Ops 0..3 load U, V, w, b one element per
// beat; op 4 starts a solve. Output channel m_axis_*: tdata =
// {solution[31:0], index[3:0]}, zero filled to 40 bits, tlast on the last
// element.
// A solve computes the projections (one multiplier dot product per row,
// then a 64-step bit-serial divide; a dropped or saturated projection
// skips the divide) and then the products with V, all through the single
// multiply-accumulate path and the divider.
// The input is not ready during a solve. When the receiver stalls the
// current result is held in the output register and the walk pauses.
// Reset (rst, synchronous) sets size to 16, cutoff to 0, clears the
// projections. Registers: APB, size at 0x0, cutoff at 0x4.
module svd_back_substitution import svdbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [2:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // index[3:0], solution[35:4], zeros
  output logic        m_axis_tlast
);
  localparam logic [3:0] S_IDLE = 4'd0, S_PRD = 4'd1, S_PACC = 4'd2,
    S_PTHR = 4'd3, S_PDIV = 4'd4, S_PWAIT = 4'd5, S_XRD = 4'd6,
    S_XACC = 4'd7, S_OUT = 4'd8;

  logic [4:0]  size_reg;
  logic [31:0] cutoff;
  logic [3:0]  state;
  logic [4:0]  n;
  logic [3:0]  i_cnt, j_cnt;
  logic [4:0]  k;
  logic        in_acc;
  logic [3:0]  row, col;
  logic [31:0] value;
  logic [2:0]  op;
  logic [127:0] acc;
  logic [63:0] prod;
  logic        prod_v;
  logic [31:0] proj [MaxDim];
  logic [MaxDim-1:0] proj_v;
  logic signed [31:0] w0, wj;
  logic [31:0] u_rd, v_rd, w_rd, b_rd;
  logic [7:0]  u_ra, v_ra;
  logic [3:0]  w_ra, b_ra;
  logic [31:0] pj;
  logic [31:0] pj_d;
  logic signed [95:0] thr_l, thr_r;
  logic        p_skip;
  logic        acc_big;
  logic [31:0] big_sat;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [31:0] xsat;
  logic [3:0]  out_idx;
  logic [31:0] out_sol;
  logic        out_last;
  logic        out_v;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, size_reg} : cutoff;
  assign row = s_axis_tdata[3:0];
  assign col = s_axis_tdata[7:4];
  assign value = s_axis_tdata[39:8];
  assign op = s_axis_tuser;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign n = (size_reg == 5'd0) ? 5'd1 : ((size_reg > 5'd16) ? 5'd16 : size_reg);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= 5'd16;
      cutoff <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2:2] == REG_SIZE[0:0]) size_reg <= pwdata[4:0];
      else if (paddr[2:2] == REG_CUTOFF[0:0]) cutoff <= pwdata;
    end
  end

  // stores
  always_comb begin
    u_ra = {j_cnt, k[3:0]};
    v_ra = {i_cnt, k[3:0]};
    w_ra = j_cnt;
    b_ra = k[3:0];
  end
  svdbs_ram #(.Width(32), .Depth(256)) u_mem (.clk, .we(in_acc && op == OP_WR_U),
    .waddr({row, col}), .wdata(value), .raddr(u_ra), .rdata(u_rd));
  svdbs_ram #(.Width(32), .Depth(256)) v_mem (.clk, .we(in_acc && op == OP_WR_V),
    .waddr({row, col}), .wdata(value), .raddr(v_ra), .rdata(v_rd));
  svdbs_ram #(.Width(32), .Depth(16)) w_mem (.clk, .we(in_acc && op == OP_WR_W),
    .waddr(row), .wdata(value), .raddr(w_ra), .rdata(w_rd));
  svdbs_ram #(.Width(32), .Depth(16)) b_mem (.clk, .we(in_acc && op == OP_WR_B),
    .waddr(row), .wdata(value), .raddr(b_ra), .rdata(b_rd));

  svdbs_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  assign pj = proj_v[k[3:0]] ? proj[k[3:0]] : 32'd0;
  assign thr_l = {{32{wj[31]}}, wj, 32'd0};
  assign thr_r = $signed({32'd0, cutoff}) * $signed({{64{w0[31]}}, w0});

  always_comb begin
    if (acc[127] && (acc[127:47] != {81{1'b1}})) xsat = 32'h8000_0000;
    else if (!acc[127] && (acc[127:47] != '0)) xsat = 32'h7FFF_FFFF;
    else xsat = acc[47:16];
  end

  // drop the projection, saturate a sum beyond 64 bits, else divide
  always_comb begin
    p_skip = (wj == 0) || (j_cnt != 4'd0 && thr_l <= thr_r);
    acc_big = (acc[127:63] != '0) && (acc[127:63] != '1);
    big_sat = (acc[127] ^ wj[31]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    dreq.start = (state == S_PTHR) && !p_skip && !acc_big;
    dreq.num = acc[63:0];
    dreq.den = wj;
  end

  // sequencer: issue reads, multiply, accumulate, divide and emit results
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      proj_v <= '0;
      prod_v <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_v || m_axis_tready)) out_v <= 1'b1;
      else if (m_axis_tready) out_v <= 1'b0;
      prod_v <= (state == S_PACC && k <= n) ||
                (state == S_XRD && k >= 5'd1 && k <= n);
      // read data is registered in the RAM, and the product is registered after it
      prod <= 64'($signed(state == S_PACC ? u_rd : pj_d) *
                  $signed(state == S_PACC ? b_rd : v_rd));
      if (prod_v) acc <= acc + {{64{prod[63]}}, prod};
      unique case (state)
        S_IDLE: if (in_acc && op == OP_SOLVE) begin
          j_cnt <= '0;
          k <= '0;
          acc <= '0;
          state <= S_PRD;
        end
        S_PRD: begin
          k <= k + 5'd1;
          state <= S_PACC;
          if (j_cnt == 4'd0) w0 <= w_rd;
        end
        S_PACC: begin
          if (k == 5'd1 && j_cnt == 4'd0) w0 <= w_rd;
          if (k == 5'd1) wj <= w_rd;
          if (k == n + 5'd2) state <= S_PTHR;
          else k <= k + 5'd1;
        end
        S_PTHR: begin
          if (dreq.start) state <= S_PDIV;
          else begin
            proj[j_cnt] <= p_skip ? '0 : big_sat;
            proj_v[j_cnt] <= 1'b1;
            state <= S_PWAIT;
          end
        end
        S_PDIV: if (drsp.done) begin
          proj[j_cnt] <= drsp.quo;
          proj_v[j_cnt] <= 1'b1;
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          acc <= '0;
          k <= '0;
          if ({1'b0, j_cnt} == n - 5'd1) begin
            i_cnt <= '0;
            state <= S_XRD;
          end else begin
            j_cnt <= j_cnt + 4'd1;
            state <= S_PRD;
          end
        end
        S_XRD: begin
          if (k < n) begin
            pj_d <= pj;
            k <= k + 5'd1;
          end
          if (k == n + 5'd2) state <= S_OUT;
          else if (k >= n) k <= k + 5'd1;
        end
        S_OUT: if (!out_v || m_axis_tready) begin
          out_idx <= i_cnt;
          out_sol <= xsat;
          out_last <= ({1'b0, i_cnt} == n - 5'd1);
          acc <= '0;
          k <= '0;
          if ({1'b0, i_cnt} == n - 5'd1) state <= S_IDLE;
          else begin
            i_cnt <= i_cnt + 4'd1;
            state <= S_XRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata = {4'd0, out_sol, out_idx};
  assign m_axis_tlast = out_last;
endmodule

/* sv/svdbs_check.sv */
module svdbs_check (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready || m_axis_tlast)
    else $error("input open during a solve");
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after last");
endmodule

bind svd_back_substitution svdbs_check u_check (.*);
